### rtl/assert_macros.svh
// Concurrent assertion helpers, clocked on clk and disabled while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define PST_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define PST_ASSERT_NEXT(lbl, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);
`else
`define PST_ASSERT(lbl, prop, msg)
`define PST_ASSERT_NEXT(lbl, pre, post, msg)
`endif
`endif

### rtl/pst_pkg.sv
package pst_pkg;
    localparam int TASK_SLOTS_DEF  = 12;
    localparam int SEM_COUNT_DEF   = 5;
    localparam int QUEUE_DEPTH_DEF = 5;

    localparam int SLOT_W = 4;
    localparam logic [3:0] PRIO_NONE = 4'd8;

    localparam logic [2:0] FN_YIELD  = 3'd0;
    localparam logic [2:0] FN_SLEEP  = 3'd1;
    localparam logic [2:0] FN_WAIT   = 3'd2;
    localparam logic [2:0] FN_POST   = 3'd3;
    localparam logic [2:0] FN_TICK   = 3'd4;
    localparam logic [2:0] FN_CTASK  = 3'd5;
    localparam logic [2:0] FN_CSEM   = 3'd6;

    localparam logic [2:0] ST_INVALID = 3'd0;
    localparam logic [2:0] ST_UNRUN   = 3'd1;
    localparam logic [2:0] ST_READY   = 3'd2;
    localparam logic [2:0] ST_DELAYED = 3'd3;
    localparam logic [2:0] ST_BLOCKED = 3'd4;

    localparam logic [2:0] RC_OK     = 3'd0;
    localparam logic [2:0] RC_FULL   = 3'd1;
    localparam logic [2:0] RC_DUP    = 3'd2;
    localparam logic [2:0] RC_BADSEM = 3'd3;
    localparam logic [2:0] RC_QFULL  = 3'd4;
    localparam logic [2:0] RC_NONE   = 3'd5;

    typedef struct packed {
        logic [2:0]  st;
        logic [2:0]  prio;
        logic [31:0] sleep;
        logic [31:0] tag;
    } task_ent_t;
endpackage

### rtl/pst_task_ram.sv
module pst_task_ram
    import pst_pkg::*;
#(
    parameter int DEPTH = TASK_SLOTS_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic [AW-1:0] rd_addr,
    output task_ent_t     rd_data,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  task_ent_t     wr_data
);
    task_ent_t        mem [DEPTH];
    task_ent_t        rd_data_reg;
    logic [DEPTH-1:0] vld_reg;
    logic             rd_vld_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    // an entry not written since reset reads as all zeros
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg    <= '0;
            rd_vld_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                vld_reg[wr_addr] <= 1'b1;
            end
            rd_vld_reg <= vld_reg[rd_addr];
        end
    end

    assign rd_data = rd_vld_reg ? rd_data_reg : '0;
endmodule

### rtl/pst_fifo_ram.sv
module pst_fifo_ram
    import pst_pkg::*;
#(
    parameter int DEPTH = SEM_COUNT_DEF * QUEUE_DEPTH_DEF,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic [AW-1:0]     rd_addr,
    output logic [SLOT_W-1:0] rd_data,
    input  logic              wr_en,
    input  logic [AW-1:0]     wr_addr,
    input  logic [SLOT_W-1:0] wr_data
);
    logic [SLOT_W-1:0] mem [DEPTH];
    logic [SLOT_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;
endmodule

### rtl/priority_task_scheduler_semaphores.sv
// Sequencing: yield, sleep, wait, post, tick and create task scan the task table memory one
// entry a cycle; a bad semaphore index, a wait taken from the count, a full table and other
// requests skip the scan, as does a wait refused on a full queue; a stalled result waits in S_DONE.
// Throughput: one request at a time; the next request is taken once the result is registered.
// Reset: asynchronous, active low; per-slot valid bits make the task table read as invalid
// at once, semaphore counters clear; no clearing pass is needed.
module priority_task_scheduler_semaphores
    import pst_pkg::*;
#(
    parameter int TASK_SLOTS  = TASK_SLOTS_DEF,
    parameter int SEM_COUNT   = SEM_COUNT_DEF,
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // func[2:0], arg_value[34:3], sem_index[37:35], priority_req[40:38], entry_tag[72:41]
    input  logic [79:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // status[2:0], switched[3], next_task[7:4], first_run[8], created_slot[12:9]
    output logic [15:0] m_axis_tdata
);
    localparam int IW  = $clog2(TASK_SLOTS);
    localparam int CW  = $clog2(TASK_SLOTS + 1);
    localparam int SW  = (SEM_COUNT > 1) ? $clog2(SEM_COUNT) : 1;
    localparam int WW  = $clog2(QUEUE_DEPTH + 1);
    localparam int QW  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int FD  = SEM_COUNT * QUEUE_DEPTH;
    localparam int FAW = (FD > 1) ? $clog2(FD) : 1;

    typedef enum logic [3:0] {
        S_IDLE, S_DECODE, S_CALLRD, S_CALLER, S_PRD, S_PHEAD, S_PTASK,
        S_SCAN, S_END, S_DONE
    } state_t;

    state_t state_reg;
    logic [2:0]  func_reg, sem_reg, prio_reg;
    logic [31:0] arg_reg, tag_reg;
    logic [SLOT_W-1:0] running_reg;
    logic [CW-1:0]     total_reg;
    logic [15:0]   sem_cnt_reg  [SEM_COUNT];
    logic [WW-1:0] sem_wait_reg [SEM_COUNT];
    logic [QW-1:0] sem_head_reg [SEM_COUNT];
    logic [IW:0]   iss_reg;
    logic          rv_reg;
    logic [IW-1:0] ridx_reg;
    logic [3:0]    best_reg;
    logic [IW-1:0] pick_reg;
    logic          pick_unrun_reg;
    task_ent_t     pick_ent_reg;
    logic          dup_reg, found_reg;
    logic [IW-1:0] free_reg;
    logic [SLOT_W-1:0] head_reg;
    logic          head_ok_reg;
    logic [2:0]    res_status_reg;
    logic          res_sw_reg, res_first_reg;
    logic [SLOT_W-1:0] res_next_reg, res_created_reg;
    logic          out_valid_reg;
    logic [15:0]   out_data_reg;

    logic [IW-1:0]     t_rd_addr, t_wr_addr;
    task_ent_t         t_rd, t_wr;
    logic              t_wr_en;
    logic [FAW-1:0]    f_rd_addr, f_wr_addr;
    logic [SLOT_W-1:0] f_rd;
    logic              f_wr_en;

    logic          sem_bad;
    logic [SW-1:0] si;
    logic          caller_runs, runnable;
    logic [WW:0]   tail_sum;
    logic [QW-1:0] tail_pos;

    pst_task_ram #(.DEPTH(TASK_SLOTS), .AW(IW)) u_task_ram (
        .clk(clk), .rst_n(rst_n), .rd_addr(t_rd_addr), .rd_data(t_rd),
        .wr_en(t_wr_en), .wr_addr(t_wr_addr), .wr_data(t_wr)
    );

    pst_fifo_ram #(.DEPTH(FD), .AW(FAW)) u_fifo_ram (
        .clk(clk), .rd_addr(f_rd_addr), .rd_data(f_rd),
        .wr_en(f_wr_en), .wr_addr(f_wr_addr), .wr_data(running_reg)
    );

    assign sem_bad     = {1'b0, sem_reg} >= 4'(SEM_COUNT);
    assign si          = sem_reg[SW-1:0];
    assign caller_runs = (t_rd.st == ST_READY) || (t_rd.st == ST_UNRUN);
    assign runnable    = caller_runs;
    assign tail_sum    = (WW+1)'(sem_head_reg[si]) + (WW+1)'(sem_wait_reg[si]);
    assign tail_pos    = (tail_sum >= (WW+1)'(QUEUE_DEPTH))
                         ? QW'(tail_sum - (WW+1)'(QUEUE_DEPTH)) : QW'(tail_sum);
    assign f_wr_addr   = FAW'(si) * FAW'(QUEUE_DEPTH) + FAW'(tail_pos);
    assign f_rd_addr   = FAW'(si) * FAW'(QUEUE_DEPTH) + FAW'(sem_head_reg[si]);

    always_comb
    begin
        t_rd_addr = running_reg[IW-1:0];
        t_wr_en   = 1'b0;
        t_wr_addr = running_reg[IW-1:0];
        t_wr      = t_rd;
        f_wr_en   = 1'b0;
        unique case (state_reg)
            S_PHEAD:
            begin
                t_rd_addr = f_rd[IW-1:0];
            end
            S_CALLER:
            begin
                if (caller_runs && func_reg == FN_SLEEP)
                begin
                    t_wr_en    = 1'b1;
                    t_wr.st    = ST_DELAYED;
                    t_wr.sleep = arg_reg;
                end
                else if (caller_runs && sem_wait_reg[si] < WW'(QUEUE_DEPTH))
                begin
                    t_wr_en = 1'b1;
                    t_wr.st = ST_BLOCKED;
                    f_wr_en = 1'b1;
                end
            end
            S_PTASK:
            begin
                t_wr_addr = head_reg[IW-1:0];
                if (head_ok_reg && t_rd.st == ST_BLOCKED)
                begin
                    t_wr_en = 1'b1;
                    t_wr.st = ST_READY;
                end
            end
            S_SCAN:
            begin
                t_rd_addr = iss_reg[IW-1:0];
                t_wr_addr = ridx_reg;
                if (rv_reg && func_reg == FN_TICK && t_rd.st == ST_DELAYED)
                begin
                    t_wr_en = 1'b1;
                    if (t_rd.sleep <= 32'd1)
                    begin
                        t_wr.sleep = '0;
                        t_wr.st    = ST_READY;
                    end
                    else
                    begin
                        t_wr.sleep = t_rd.sleep - 32'd1;
                    end
                end
            end
            S_END:
            begin
                if (func_reg == FN_CTASK)
                begin
                    t_wr_addr = free_reg;
                    t_wr_en   = found_reg && !dup_reg;
                    t_wr      = '{st: ST_UNRUN, prio: prio_reg, sleep: '0, tag: tag_reg};
                end
                else if (func_reg != FN_TICK)
                begin
                    t_wr_addr = pick_reg;
                    t_wr_en   = best_reg != PRIO_NONE;
                    t_wr      = pick_ent_reg;
                    t_wr.st   = ST_READY;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            running_reg   <= '0;
            total_reg     <= '0;
            out_valid_reg <= 1'b0;
            iss_reg       <= '0;
            rv_reg        <= 1'b0;
            for (int k = 0; k < SEM_COUNT; k++)
            begin
                sem_cnt_reg[k]  <= '0;
                sem_wait_reg[k] <= '0;
                sem_head_reg[k] <= '0;
            end
        end
        else
        begin
            if (state_reg == S_DONE && (!out_valid_reg || m_axis_tready))
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (s_axis_tvalid)
                    begin
                        func_reg  <= s_axis_tdata[2:0];
                        arg_reg   <= s_axis_tdata[34:3];
                        sem_reg   <= s_axis_tdata[37:35];
                        prio_reg  <= s_axis_tdata[40:38];
                        tag_reg   <= s_axis_tdata[72:41];
                        state_reg <= S_DECODE;
                    end
                end
                S_DECODE:
                begin
                    res_sw_reg      <= 1'b0;
                    res_first_reg   <= 1'b0;
                    res_next_reg    <= '0;
                    res_created_reg <= '0;
                    iss_reg         <= '0;
                    rv_reg          <= 1'b0;
                    best_reg        <= PRIO_NONE;
                    dup_reg         <= 1'b0;
                    found_reg       <= 1'b0;
                    unique case (func_reg)
                        FN_YIELD, FN_TICK:
                        begin
                            res_status_reg <= RC_OK;
                            state_reg      <= S_SCAN;
                        end
                        FN_SLEEP:
                        begin
                            res_status_reg <= RC_OK;
                            state_reg      <= S_CALLRD;
                        end
                        FN_WAIT:
                        begin
                            if (sem_bad)
                            begin
                                res_status_reg <= RC_BADSEM;
                                state_reg      <= S_DONE;
                            end
                            else if (sem_cnt_reg[si] != '0)
                            begin
                                res_status_reg  <= RC_OK;
                                sem_cnt_reg[si] <= sem_cnt_reg[si] - 16'd1;
                                state_reg       <= S_DONE;
                            end
                            else
                            begin
                                res_status_reg <= RC_OK;
                                state_reg      <= S_CALLRD;
                            end
                        end
                        FN_POST:
                        begin
                            if (sem_bad)
                            begin
                                res_status_reg <= RC_BADSEM;
                                state_reg      <= S_DONE;
                            end
                            else if (sem_wait_reg[si] != '0)
                            begin
                                res_status_reg <= RC_OK;
                                state_reg      <= S_PRD;
                            end
                            else
                            begin
                                res_status_reg <= RC_OK;
                                if (sem_cnt_reg[si] != 16'hFFFF)
                                    sem_cnt_reg[si] <= sem_cnt_reg[si] + 16'd1;
                                state_reg <= S_SCAN;
                            end
                        end
                        FN_CTASK:
                        begin
                            if (total_reg >= CW'(TASK_SLOTS))
                            begin
                                res_status_reg <= RC_FULL;
                                state_reg      <= S_DONE;
                            end
                            else
                            begin
                                res_status_reg <= RC_OK;
                                state_reg      <= S_SCAN;
                            end
                        end
                        FN_CSEM:
                        begin
                            state_reg <= S_DONE;
                            if (sem_bad)
                                res_status_reg <= RC_BADSEM;
                            else
                            begin
                                res_status_reg  <= RC_OK;
                                sem_cnt_reg[si] <= (|arg_reg[31:16]) ? 16'hFFFF
                                                                      : arg_reg[15:0];
                            end
                        end
                        default:
                        begin
                            res_status_reg <= RC_OK;
                            state_reg      <= S_DONE;
                        end
                    endcase
                end
                S_CALLRD: state_reg <= S_CALLER;
                S_CALLER:
                begin
                    if (func_reg == FN_WAIT && caller_runs
                        && sem_wait_reg[si] >= WW'(QUEUE_DEPTH))
                    begin
                        res_status_reg <= RC_QFULL;
                        state_reg      <= S_DONE;
                    end
                    else
                    begin
                        if (func_reg == FN_WAIT && caller_runs)
                            sem_wait_reg[si] <= sem_wait_reg[si] + WW'(1);
                        state_reg <= S_SCAN;
                    end
                end
                S_PRD: state_reg <= S_PHEAD;
                S_PHEAD:
                begin
                    head_reg         <= f_rd;
                    head_ok_reg      <= {1'b0, f_rd} < (SLOT_W+1)'(TASK_SLOTS);
                    sem_wait_reg[si] <= sem_wait_reg[si] - WW'(1);
                    sem_head_reg[si] <= (sem_head_reg[si] == QW'(QUEUE_DEPTH - 1))
                                        ? '0 : sem_head_reg[si] + QW'(1);
                    state_reg        <= S_PTASK;
                end
                S_PTASK: state_reg <= S_SCAN;
                S_SCAN:
                begin
                    if (iss_reg < (IW+1)'(TASK_SLOTS))
                        iss_reg <= iss_reg + (IW+1)'(1);
                    rv_reg   <= iss_reg < (IW+1)'(TASK_SLOTS);
                    ridx_reg <= iss_reg[IW-1:0];
                    if (rv_reg)
                    begin
                        if (runnable && {1'b0, t_rd.prio} < best_reg)
                        begin
                            best_reg       <= {1'b0, t_rd.prio};
                            pick_reg       <= ridx_reg;
                            pick_unrun_reg <= t_rd.st == ST_UNRUN;
                            pick_ent_reg   <= t_rd;
                        end
                        if (t_rd.st != ST_INVALID && t_rd.tag == tag_reg)
                            dup_reg <= 1'b1;
                        if (t_rd.st == ST_INVALID && !found_reg)
                        begin
                            found_reg <= 1'b1;
                            free_reg  <= ridx_reg;
                        end
                        if (ridx_reg == IW'(TASK_SLOTS - 1))
                            state_reg <= S_END;
                    end
                end
                S_END:
                begin
                    state_reg <= S_DONE;
                    if (func_reg == FN_CTASK)
                    begin
                        if (dup_reg)
                            res_status_reg <= RC_DUP;
                        else if (!found_reg)
                            res_status_reg <= RC_FULL;
                        else
                        begin
                            total_reg       <= total_reg + CW'(1);
                            res_created_reg <= SLOT_W'(free_reg);
                        end
                    end
                    else if (func_reg != FN_TICK)
                    begin
                        if (best_reg == PRIO_NONE)
                            res_status_reg <= RC_NONE;
                        else
                        begin
                            running_reg   <= SLOT_W'(pick_reg);
                            res_sw_reg    <= 1'b1;
                            res_next_reg  <= SLOT_W'(pick_reg);
                            res_first_reg <= pick_unrun_reg;
                        end
                    end
                end
                S_DONE:
                begin
                    if (!out_valid_reg || m_axis_tready)
                    begin
                        out_data_reg  <= {3'b000, res_created_reg, res_first_reg,
                                          res_next_reg, res_sw_reg, res_status_reg};
                        state_reg     <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign s_axis_tready = state_reg == S_IDLE;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

`include "assert_macros.svh"
    `PST_ASSERT(a_sw_ok, !(m_axis_tvalid && m_axis_tdata[3]) || m_axis_tdata[2:0] == RC_OK, "bad sw")
    `PST_ASSERT_NEXT(a_one_req, s_axis_tvalid && s_axis_tready, !s_axis_tready, "busy accept")
    `PST_ASSERT(a_total, total_reg <= CW'(TASK_SLOTS), "task count above table size")
    `PST_ASSERT(a_running, {1'b0, running_reg} < (SLOT_W+1)'(TASK_SLOTS), "running slot out")
endmodule

### verif/pst_checker.sv
`timescale 1ns / 1ps

module pst_checker
    import pst_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [79:0] s_axis_tdata,
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [15:0] m_axis_tdata,
    output int          fail_count,
    output int          pending_replies,
    output int          replies_seen
);
    localparam int NT = TASK_SLOTS_DEF;
    localparam int NS = SEM_COUNT_DEF;
    localparam int QD = QUEUE_DEPTH_DEF;

    // last member sits in the lowest bits
    typedef struct packed {
        logic [3:0] created_slot;
        logic       first_run;
        logic [3:0] next_task;
        logic       switched;
        logic [2:0] status;
    } reply_t;

    logic [2:0]  tstate [NT];
    logic [2:0]  tprio  [NT];
    logic [31:0] tsleep [NT];
    logic [31:0] ttag   [NT];
    logic [3:0]  cur_task;
    logic [3:0]  live_tasks;
    logic [15:0] scount [NS];
    logic [2:0]  swait  [NS];
    logic [3:0]  squeue [NS][QD];

    reply_t reply_q[$];

    function automatic bit cur_runs();
        if (cur_task >= NT) return 0;
        return tstate[cur_task] == ST_READY || tstate[cur_task] == ST_UNRUN;
    endfunction

    function automatic void pick_next(ref reply_t r);
        logic [3:0] best;
        int pick;
        best = PRIO_NONE;
        pick = 0;
        for (int i = 0; i < NT; i++)
            if ((tstate[i] == ST_READY || tstate[i] == ST_UNRUN) && {1'b0, tprio[i]} < best)
            begin
                best = {1'b0, tprio[i]};
                pick = i;
            end
        if (best == PRIO_NONE)
        begin
            r.status = RC_NONE;
            return;
        end
        r.switched = 1;
        r.next_task = pick[3:0];
        r.first_run = tstate[pick] == ST_UNRUN;
        tstate[pick] = ST_READY;
        cur_task = pick[3:0];
    endfunction

    function automatic reply_t kernel_call(logic [79:0] d);
        logic [2:0]  fn;
        logic [31:0] arg;
        logic [2:0]  sem;
        logic [2:0]  pr;
        logic [31:0] tag;
        reply_t r;
        int slot;
        bit dup;
        logic [3:0] head;
        fn = d[2:0];
        arg = d[34:3];
        sem = d[37:35];
        pr = d[40:38];
        tag = d[72:41];
        r = '0;
        case (fn)
            FN_YIELD: pick_next(r);
            FN_SLEEP:
            begin
                if (cur_runs())
                begin
                    tsleep[cur_task] = arg;
                    tstate[cur_task] = ST_DELAYED;
                end
                pick_next(r);
            end
            FN_WAIT:
            begin
                if (sem >= NS) r.status = RC_BADSEM;
                else if (scount[sem] > 0) scount[sem]--;
                else if (!cur_runs()) pick_next(r);
                else if (swait[sem] >= QD) r.status = RC_QFULL;
                else
                begin
                    squeue[sem][swait[sem]] = cur_task;
                    swait[sem]++;
                    tstate[cur_task] = ST_BLOCKED;
                    pick_next(r);
                end
            end
            FN_POST:
            begin
                if (sem >= NS) r.status = RC_BADSEM;
                else
                begin
                    if (swait[sem] > 0)
                    begin
                        head = squeue[sem][0];
                        if (head < NT && tstate[head] == ST_BLOCKED) tstate[head] = ST_READY;
                        swait[sem]--;
                        for (int i = 0; i + 1 < QD && i < swait[sem]; i++)
                            squeue[sem][i] = squeue[sem][i + 1];
                    end
                    else if (scount[sem] != 16'hFFFF) scount[sem]++;
                    pick_next(r);
                end
            end
            FN_TICK:
                for (int i = 0; i < NT; i++)
                    if (tstate[i] == ST_DELAYED)
                    begin
                        if (tsleep[i] <= 1)
                        begin
                            tsleep[i] = 0;
                            tstate[i] = ST_READY;
                        end
                        else tsleep[i]--;
                    end
            FN_CTASK:
            begin
                slot = NT;
                dup = 0;
                if (live_tasks >= NT) r.status = RC_FULL;
                else
                begin
                    for (int i = 0; i < NT; i++)
                    begin
                        if (tstate[i] != ST_INVALID && ttag[i] == tag) dup = 1;
                        if (tstate[i] == ST_INVALID && slot == NT) slot = i;
                    end
                    if (dup) r.status = RC_DUP;
                    else if (slot == NT) r.status = RC_FULL;
                    else
                    begin
                        tstate[slot] = ST_UNRUN;
                        tprio[slot] = pr;
                        ttag[slot] = tag;
                        tsleep[slot] = 0;
                        live_tasks++;
                        r.created_slot = slot[3:0];
                    end
                end
            end
            FN_CSEM:
            begin
                if (sem >= NS) r.status = RC_BADSEM;
                else scount[sem] = (arg > 32'hFFFF) ? 16'hFFFF : arg[15:0];
            end
            default: ;
        endcase
        return r;
    endfunction

    assign pending_replies = reply_q.size();

    always @(posedge clk)
    begin
        reply_t got;
        reply_t want;
        if (!rst_n)
        begin
            fail_count = 0;
            replies_seen = 0;
            cur_task = 0;
            live_tasks = 0;
            for (int i = 0; i < NT; i++)
            begin
                tstate[i] = ST_INVALID;
                tprio[i] = 0;
                tsleep[i] = 0;
                ttag[i] = 0;
            end
            for (int s = 0; s < NS; s++)
            begin
                scount[s] = 0;
                swait[s] = 0;
                for (int j = 0; j < QD; j++) squeue[s][j] = 0;
            end
            reply_q.delete();
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready) reply_q.push_back(kernel_call(s_axis_tdata));
            if (m_axis_tvalid && m_axis_tready)
            begin
                got = m_axis_tdata[12:0];
                replies_seen++;
                if (reply_q.size() == 0)
                begin
                    $error("reply with nothing expected: %h", m_axis_tdata);
                    fail_count++;
                end
                else
                begin
                    want = reply_q.pop_front();
                    if (got.status !== want.status)
                    begin
                        $error("status: expected %0d actual %0d", want.status, got.status);
                        fail_count++;
                    end
                    if (got.switched !== want.switched)
                    begin
                        $error("switched: expected %0d actual %0d", want.switched, got.switched);
                        fail_count++;
                    end
                    if (got.next_task !== want.next_task)
                    begin
                        $error("next_task: expected %0d actual %0d",
                               want.next_task, got.next_task);
                        fail_count++;
                    end
                    if (got.first_run !== want.first_run)
                    begin
                        $error("first_run: expected %0d actual %0d",
                               want.first_run, got.first_run);
                        fail_count++;
                    end
                    if (got.created_slot !== want.created_slot)
                    begin
                        $error("created_slot: expected %0d actual %0d",
                               want.created_slot, got.created_slot);
                        fail_count++;
                    end
                end
            end
        end
    end
endmodule

### verif/tb_priority_task_scheduler_semaphores.sv
`timescale 1ns / 1ps

module tb_priority_task_scheduler_semaphores
    import pst_pkg::*;
;
    localparam int WATCHDOG_LIMIT = 5000;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    // func[2:0], arg_value[34:3], sem_index[37:35], priority_req[40:38], entry_tag[72:41]
    logic [79:0] s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    // status[2:0], switched[3], next_task[7:4], first_run[8], created_slot[12:9]
    logic [15:0] m_axis_tdata;

    int fail_count;
    int pending_replies;
    int replies_seen;
    int idle_cycles;
    int requests_sent;
    bit calm_stretch;
    logic [31:0] tag_pool [8];

    priority_task_scheduler_semaphores dut (.*);

    pst_checker u_checker (.*);

    initial clk = 0;
    always
    begin
        #5 clk = 1;
        #5 clk = 0;
    end

    function automatic logic [79:0] pack_request(logic [2:0] fn, logic [31:0] arg,
                                                 logic [2:0] sem, logic [2:0] pr,
                                                 logic [31:0] tag);
        return {7'd0, tag, pr, sem, arg, fn};
    endfunction

    always @(posedge clk)
    begin
        if (!rst_n) m_axis_tready <= 0;
        else m_axis_tready <= calm_stretch || ($urandom_range(99) >= 17);
    end

    always @(posedge clk)
    begin
        if (!rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("watchdog: no handshake for %0d cycles", WATCHDOG_LIMIT);
            $display("tb_priority_task_scheduler_semaphores: FAIL");
            $finish;
        end
    end

    // drop valid at random before a request, never in the calm stretch, so requests there follow back to back
    task automatic send_request(logic [79:0] d);
        if (!calm_stretch)
            while ($urandom_range(99) < 17)
            begin
                s_axis_tvalid <= 0;
                @(posedge clk);
            end
        s_axis_tvalid <= 1;
        s_axis_tdata <= d;
        @(posedge clk);
        while (!s_axis_tready) @(posedge clk);
        requests_sent++;
    endtask

    function automatic logic [79:0] random_request();
        logic [2:0] fn;
        logic [31:0] arg;
        logic [2:0] sem;
        int pick;
        pick = $urandom_range(99);
        if (pick < 12) fn = FN_YIELD;
        else if (pick < 24) fn = FN_SLEEP;
        else if (pick < 40) fn = FN_WAIT;
        else if (pick < 56) fn = FN_POST;
        else if (pick < 74) fn = FN_TICK;
        else if (pick < 88) fn = FN_CTASK;
        else if (pick < 96) fn = FN_CSEM;
        else fn = 3'd7;
        sem = ($urandom_range(9) == 0) ? 3'($urandom_range(7, 5)) : 3'($urandom_range(4));
        case ($urandom_range(3))
            0: arg = $urandom;
            1: arg = 0;
            default: arg = $urandom_range(6);
        endcase
        // reuse tags often so duplicates show up
        return pack_request(fn, arg, sem, 3'($urandom),
                            ($urandom_range(2) == 0) ? $urandom : tag_pool[$urandom_range(7)]);
    endfunction

    initial
    begin
        rst_n = 0;
        s_axis_tvalid = 0;
        s_axis_tdata = '0;
        calm_stretch = 0;
        requests_sent = 0;
        for (int i = 0; i < 8; i++) tag_pool[i] = $urandom;
        tag_pool[0] = 32'hFFFF_FFFF;
        tag_pool[1] = 0;
        repeat (6) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // directed: empty table, bad semaphores, saturation, full table
        send_request(pack_request(FN_YIELD, 0, 0, 0, 0));
        send_request(pack_request(FN_WAIT, 0, 7, 0, 0));
        send_request(pack_request(FN_POST, 0, 5, 0, 0));
        send_request(pack_request(FN_CSEM, 32'hFFFF_FFFF, 6, 0, 0));
        send_request(pack_request(FN_CSEM, 32'hFFFF_FFFF, 0, 0, 0));
        send_request(pack_request(FN_POST, 0, 0, 0, 0));
        send_request(pack_request(FN_WAIT, 0, 0, 0, 0));
        send_request(pack_request(FN_CTASK, 0, 0, 7, 32'hFFFF_FFFF));
        send_request(pack_request(FN_CTASK, 0, 0, 0, 32'hFFFF_FFFF));
        send_request(pack_request(FN_CTASK, 0, 0, 0, 0));
        send_request(pack_request(FN_YIELD, 0, 0, 0, 0));
        send_request(pack_request(FN_SLEEP, 0, 0, 0, 0));
        send_request(pack_request(FN_TICK, 0, 0, 0, 0));
        send_request(pack_request(FN_WAIT, 0, 4, 0, 0));
        send_request(pack_request(FN_POST, 0, 4, 0, 0));
        send_request(pack_request(FN_SLEEP, 32'hFFFF_FFFF, 0, 0, 0));
        for (int i = 1; i <= 11; i++)
            send_request(pack_request(FN_CTASK, 0, 0, 3'(i), i * 32'h1111));
        send_request(pack_request(FN_CTASK, 0, 0, 0, 32'h5A5A));
        send_request(pack_request(3'd7, 32'hFFFF_FFFF, 7, 7, 32'hFFFF_FFFF));

        for (int n = 0; n < 1850; n++)
        begin
            calm_stretch = (n >= 600 && n < 800);
            send_request(random_request());
        end
        calm_stretch = 0;
        s_axis_tvalid <= 0;

        while (pending_replies != 0) @(posedge clk);
        repeat (40) @(posedge clk);
        $display("ran %0d kernel calls, %0d replies checked, through full tables,",
                 requests_sent, replies_seen);
        $display("semaphore queues, sleeps, ticks and bad indexes");
        if (fail_count == 0 && pending_replies == 0)
            $display("tb_priority_task_scheduler_semaphores: PASS");
        else
            $display("tb_priority_task_scheduler_semaphores: FAIL");
        $finish;
    end
endmodule
